[sv/sbf_pkg.sv]
// shared constants, state type and controller/datapath interface structs
package sbf_pkg;

    localparam int FRAME_LEN    = 25;
    localparam int FLAGS_POS    = 23;
    localparam int FOOTER_POS   = 24;
    localparam int CHANNELS     = 16;
    localparam int CH_BITS      = 11;
    localparam int SCAN_CHANNELS = 4;
    localparam int RAW_BITS     = CHANNELS * CH_BITS;
    localparam int FILL_W       = $clog2(FRAME_LEN + 1);
    localparam int CH_IDX_W     = $clog2(CHANNELS);

    localparam logic [7:0]  HEADER_BYTE     = 8'h0F;
    localparam logic [7:0]  FOOTER_A        = 8'h00;
    localparam logic [7:0]  FOOTER_B        = 8'h04;
    localparam logic [7:0]  FOOTER_C        = 8'h14;
    localparam logic [7:0]  FOOTER_D        = 8'h24;
    localparam logic [7:0]  FOOTER_E        = 8'h34;
    localparam logic [7:0]  FLAGS_HI_MASK   = 8'hF0;
    localparam logic [7:0]  DEBOUNCE_RESET  = 8'd20;
    localparam logic [11:0] MIN_VALID_RESET = 12'd800;
    localparam logic [11:0] SCALE_OFFSET    = 12'd875;

    localparam logic [1:0] CFG_DEBOUNCE  = 2'd0;
    localparam logic [1:0] CFG_MIN_VALID = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RESYNC,
        ST_SCAN,
        ST_DEBOUNCE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic store;
        logic load_chan;
        logic resync_shift;
        logic check_step;
        logic debounce;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic fill_last;
        logic frame_ok;
        logic resync_done;
        logic scan_last;
        logic emit_last;
        logic out_free;
    } status_t;

endpackage

[sv/sbus_frame_decoder_core.sv]
// s.bus frame decoder top level: controller and datapath
//
//  channel  ports                                   direction  transaction
//  s_       s_valid s_ready s_rx_byte               in         one received byte
//  m_       m_valid m_ready m_channel_index         out        one scaled channel
//           m_channel_value m_failsafe m_last
//  cfg_     cfg_valid cfg_ready cfg_index cfg_data  in         register write
//
// bytes are taken while idle; the 25th byte of a good frame holds off s_ready
// through the check, scan, debounce and emit states
// rejected frames realign one byte per cycle with s_ready low until a header leads
// m_ready low stalls the emit phase while a result is held
// synchronous active-low reset, no clearing pass; the frame buffer is not reset
// cfg_ready is always high
module sbus_frame_decoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_channel_index,
    output logic [11:0] m_channel_value,
    output logic        m_failsafe,
    output logic        m_last
);
    import sbf_pkg::*;

    cmd_t    cmd;
    status_t status;

    sbf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sbf_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_rx_byte       (s_rx_byte),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_channel_index (m_channel_index),
        .m_channel_value (m_channel_value),
        .m_failsafe      (m_failsafe),
        .m_last          (m_last)
    );

endmodule

[sv/sbf_ctrl.sv]
// frame sequencing state machine
module sbf_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  sbf_pkg::status_t status,
    output sbf_pkg::cmd_t    cmd
);
    import sbf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && status.fill_last) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = status.frame_ok ? ST_SCAN : ST_RESYNC;
            end
            ST_RESYNC: begin
                if (status.resync_done) state_next = ST_IDLE;
            end
            ST_SCAN: begin
                if (status.scan_last) state_next = ST_DEBOUNCE;
            end
            ST_DEBOUNCE: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free && status.emit_last) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.store = s_valid;
            end
            ST_CHECK: begin
                cmd.load_chan    = status.frame_ok;
                cmd.resync_shift = !status.frame_ok;
            end
            ST_RESYNC: begin
                cmd.resync_shift = !status.resync_done;
            end
            ST_SCAN: begin
                cmd.check_step = 1'b1;
            end
            ST_DEBOUNCE: begin
                cmd.debounce = 1'b1;
            end
            ST_EMIT: begin
                cmd.emit = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

[sv/sbf_datapath.sv]
// frame buffer, channel unpacking, scaling, failsafe debounce and result register
module sbf_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sbf_pkg::cmd_t                 cmd,
    output sbf_pkg::status_t              status,
    input  logic [7:0]                    s_rx_byte,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [11:0]                   cfg_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sbf_pkg::CH_IDX_W-1:0]  m_channel_index,
    output logic [11:0]                   m_channel_value,
    output logic                          m_failsafe,
    output logic                          m_last
);
    import sbf_pkg::*;

    logic [7:0]          buf_reg [FRAME_LEN];
    logic [7:0]          buf_next [FRAME_LEN];
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [RAW_BITS-1:0] chan_reg, chan_next;
    logic [RAW_BITS-1:0] frame_bits;
    logic [CH_IDX_W-1:0] step_reg, step_next;
    logic                fs_reg, fs_next;
    logic [7:0]          bad_reg, bad_next;
    logic [7:0]          good_reg, good_next;
    logic                latch_reg, latch_next;
    logic [7:0]          db_reg;
    logic [11:0]         min_valid_reg;
    logic                m_valid_reg, m_valid_next;
    logic [CH_IDX_W-1:0] m_index_reg, m_index_next;
    logic [11:0]         m_value_reg, m_value_next;
    logic                m_fs_reg, m_fs_next;
    logic                m_last_reg, m_last_next;
    logic [CH_BITS-1:0]  scan_raw;
    logic [11:0]         scan_value;
    logic [7:0]          bad_inc, good_inc;

    // raw*1000/1600 is exactly raw*5/8
    function automatic logic [11:0] sbf_scale(input logic [CH_BITS-1:0] raw);
        logic [CH_BITS+2:0] prod;
        prod = {1'b0, raw, 2'b00} + {3'b000, raw};
        return {1'b0, prod[CH_BITS+2:3]} + SCALE_OFFSET;
    endfunction

    function automatic logic footer_ok(input logic [7:0] f);
        logic ok;
        case (f) inside
            FOOTER_A, FOOTER_B, FOOTER_C, FOOTER_D, FOOTER_E: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    // channel data bytes 1..22, first byte at the lsb end
    always_comb begin
        for (int i = 0; i < RAW_BITS / 8; i++) begin
            frame_bits[i*8 +: 8] = buf_reg[i+1];
        end
    end

    always_comb begin
        case (step_reg[1:0])
            2'd0:    scan_raw = chan_reg[0*CH_BITS +: CH_BITS];
            2'd1:    scan_raw = chan_reg[1*CH_BITS +: CH_BITS];
            2'd2:    scan_raw = chan_reg[2*CH_BITS +: CH_BITS];
            default: scan_raw = chan_reg[3*CH_BITS +: CH_BITS];
        endcase
        scan_value = sbf_scale(scan_raw);
    end

    always_comb begin
        buf_next  = buf_reg;
        fill_next = fill_reg;
        if (cmd.store && (fill_reg != '0 || s_rx_byte == HEADER_BYTE)) begin
            buf_next[fill_reg] = s_rx_byte;
            fill_next          = fill_reg + 1'b1;
        end
        if (cmd.resync_shift) begin
            for (int i = 0; i < FRAME_LEN - 1; i++) begin
                buf_next[i] = buf_reg[i+1];
            end
            fill_next = fill_reg - 1'b1;
        end
        if (cmd.load_chan) fill_next = '0;
    end

    always_comb begin
        chan_next = chan_reg;
        step_next = step_reg;
        fs_next   = fs_reg;
        if (cmd.load_chan) begin
            chan_next = frame_bits;
            step_next = '0;
            fs_next   = buf_reg[FLAGS_POS][3] & buf_reg[FLAGS_POS][2];
        end
        if (cmd.check_step) begin
            step_next = step_reg + 1'b1;
            if (scan_value < min_valid_reg) fs_next = 1'b1;
        end
        if (cmd.debounce) step_next = '0;
        if (cmd.emit) begin
            chan_next = chan_reg >> CH_BITS;
            step_next = step_reg + 1'b1;
        end
    end

    // saturating counters, latch moves once a counter reaches the threshold
    always_comb begin
        bad_inc    = (bad_reg < db_reg) ? bad_reg + 8'd1 : bad_reg;
        good_inc   = (good_reg < db_reg) ? good_reg + 8'd1 : good_reg;
        bad_next   = bad_reg;
        good_next  = good_reg;
        latch_next = latch_reg;
        if (cmd.debounce) begin
            if (fs_reg) begin
                good_next = '0;
                bad_next  = bad_inc;
                if (bad_inc >= db_reg) latch_next = 1'b1;
            end else begin
                bad_next  = '0;
                good_next = good_inc;
                if (good_inc >= db_reg) latch_next = 1'b0;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_index_next = m_index_reg;
        m_value_next = m_value_reg;
        m_fs_next    = m_fs_reg;
        m_last_next  = m_last_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
            m_index_next = step_reg;
            m_value_next = sbf_scale(chan_reg[CH_BITS-1:0]);
            m_fs_next    = latch_reg;
            m_last_next  = (step_reg == CH_IDX_W'(CHANNELS - 1));
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg     <= buf_next;
        chan_reg    <= chan_next;
        fs_reg      <= fs_next;
        m_index_reg <= m_index_next;
        m_value_reg <= m_value_next;
        m_fs_reg    <= m_fs_next;
        m_last_reg  <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            step_reg      <= '0;
            bad_reg       <= '0;
            good_reg      <= '0;
            latch_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
            db_reg        <= DEBOUNCE_RESET;
            min_valid_reg <= MIN_VALID_RESET;
        end else begin
            fill_reg    <= fill_next;
            step_reg    <= step_next;
            bad_reg     <= bad_next;
            good_reg    <= good_next;
            latch_reg   <= latch_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_DEBOUNCE:  db_reg        <= cfg_data[7:0];
                    CFG_MIN_VALID: min_valid_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign cfg_ready       = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_channel_index = m_index_reg;
    assign m_channel_value = m_value_reg;
    assign m_failsafe      = m_fs_reg;
    assign m_last          = m_last_reg;

    assign status.fill_last   = (fill_reg == FILL_W'(FRAME_LEN - 1));
    assign status.frame_ok    = footer_ok(buf_reg[FOOTER_POS])
                                && ((buf_reg[FLAGS_POS] & FLAGS_HI_MASK) == 8'h00);
    assign status.resync_done = (fill_reg == '0) || (buf_reg[0] == HEADER_BYTE);
    assign status.scan_last   = (step_reg[1:0] == 2'(SCAN_CHANNELS - 1));
    assign status.emit_last   = (step_reg == CH_IDX_W'(CHANNELS - 1));
    assign status.out_free    = !m_valid_reg || m_ready;

    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(FRAME_LEN))
        else $error("fill count beyond frame length");

    a_header_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg != '0 && !cmd.resync_shift) |-> buf_reg[0] == HEADER_BYTE)
        else $error("buffered frame does not start with a header");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> m_index_reg == CH_IDX_W'(CHANNELS - 1))
        else $error("last flag on a channel other than the final one");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> !$past(cmd.emit))
        else $error("result overwritten while stalled");

endmodule
